// File: rtl/tlrb_pkg.sv
// ----------------------------------------------------------------------------
// tlrb_pkg
// Shared types and codes for the trace log ring buffer.
// ----------------------------------------------------------------------------
package tlrb_pkg;

    localparam int FILL_W = 11;
    localparam int MODE_W = 3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam int MODE_AUTOSTOP_BIT = 1;
    localparam int MODE_CLEAR_BIT    = 2;

    typedef struct packed {
        logic [15:0] log_type;
        logic [31:0] info_first;
        logic [31:0] info_second;
        logic [31:0] info_third;
        logic [31:0] timestamp;
    } trace_rec_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [15:0]       log_type;
        logic [31:0]       info_first;
        logic [31:0]       info_second;
        logic [31:0]       info_third;
        logic [31:0]       timestamp;
        logic [MODE_W-1:0] new_trace_mode;
    } in_word_t;

    typedef struct packed {
        logic              status;
        logic [15:0]       out_type;
        logic [31:0]       out_info_first;
        logic [31:0]       out_info_second;
        logic [31:0]       out_info_third;
        logic [31:0]       out_time;
        logic [FILL_W-1:0] fill_level;
        logic [MODE_W-1:0] current_trace_mode;
    } out_word_t;

endpackage

// File: rtl/tlrb_mem.sv
// ----------------------------------------------------------------------------
// tlrb_mem
// Record memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlrb_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tlrb_pkg::trace_rec_t wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tlrb_pkg::trace_rec_t rd_data
);
    import tlrb_pkg::*;

    trace_rec_t mem [DEPTH];
    trace_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tlrb_ctrl.sv
// ----------------------------------------------------------------------------
// tlrb_ctrl
// Pointer, count and mode control with the output word register.
// ----------------------------------------------------------------------------
module tlrb_ctrl #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int CNT_W  = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tlrb_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tlrb_pkg::out_word_t  out_data,
    output logic                 mem_wr_en,
    output logic [ADDR_W-1:0]    mem_wr_addr,
    output tlrb_pkg::trace_rec_t mem_wr_data,
    output logic                 mem_rd_en,
    output logic [ADDR_W-1:0]    mem_rd_addr,
    input  tlrb_pkg::trace_rec_t mem_rd_data
);
    import tlrb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RD_WAIT
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_PTR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg, out_data_next;

    logic              accept;
    logic [ADDR_W-1:0] wr_ptr_inc;
    logic [ADDR_W-1:0] rd_ptr_inc;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign wr_ptr_inc = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
    assign fill_ext   = {{FILL_W{1'b0}}, count_next};

    assign mem_wr_addr = wr_ptr_reg;
    assign mem_rd_addr = rd_ptr_reg;
    assign mem_wr_data = '{log_type:    in_data.log_type,
                           info_first:  in_data.info_first,
                           info_second: in_data.info_second,
                           info_third:  in_data.info_third,
                           timestamp:   in_data.timestamp};

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_data_next = '0;
                    out_valid_next = 1'b1;
                    unique case (in_data.mode)
                        OP_WRITE:
                        begin
                            if (mode_reg != '0)
                            begin
                                mem_wr_en   = 1'b1;
                                wr_ptr_next = wr_ptr_inc;
                                if (count_reg != FULL_CNT)
                                begin
                                    count_next = count_reg + 1'b1;
                                    if ((count_next == FULL_CNT) &&
                                        mode_reg[MODE_AUTOSTOP_BIT])
                                    begin
                                        mode_next = '0;
                                    end
                                end
                                else
                                begin
                                    rd_ptr_next = wr_ptr_inc;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_rd_en      = 1'b1;
                                count_next     = count_reg - 1'b1;
                                rd_ptr_next    = rd_ptr_inc;
                                out_valid_next = 1'b0;
                                state_next     = ST_RD_WAIT;
                            end
                            else
                            begin
                                out_data_next.status = 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            if (in_data.new_trace_mode[MODE_CLEAR_BIT])
                            begin
                                count_next  = '0;
                                rd_ptr_next = '0;
                                wr_ptr_next = '0;
                            end
                            mode_next = in_data.new_trace_mode;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_data_next.fill_level         = fill_ext[FILL_W-1:0];
                    out_data_next.current_trace_mode = mode_next;
                end
            end
            ST_RD_WAIT:
            begin
                out_valid_next                   = 1'b1;
                out_data_next.status             = 1'b0;
                out_data_next.out_type           = mem_rd_data.log_type;
                out_data_next.out_info_first     = mem_rd_data.info_first;
                out_data_next.out_info_second    = mem_rd_data.info_second;
                out_data_next.out_info_third     = mem_rd_data.info_third;
                out_data_next.out_time           = mem_rd_data.timestamp;
                out_data_next.fill_level         = fill_ext[FILL_W-1:0];
                out_data_next.current_trace_mode = mode_reg;
                state_next                       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Entry count exceeds the ring depth.");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_data.mode == OP_READ) && (count_reg != '0)
        |=> (state_reg == ST_RD_WAIT) && !out_valid_reg)
        else $error("Read of a stored word did not wait for memory data.");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_WAIT |=> out_valid_reg && !out_data_reg.status)
        else $error("Memory read did not produce a result word.");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_WAIT |-> !in_ready)
        else $error("Input accepted while a read is in flight.");

    a_wrap_full: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == FULL_CNT |-> rd_ptr_reg == wr_ptr_reg)
        else $error("Full ring with read and write pointers apart.");

endmodule

// File: rtl/trace_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// trace_log_ring_buffer
// Circular trace record buffer with overwrite on full and optional autostop.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries one operation: write a trace record, read the oldest
// record, or start with a new trace mode. Every input word yields exactly one
// output word on the out channel, both with valid/ready handshakes.
// A write, a start, an unused code and a read of an empty ring produce their
// output word in the cycle after acceptance, and the block can accept one
// such word per cycle while the receiver takes each output word. A read of a
// stored record passes the record memory's read register, then the output
// register, and no input word is taken while the read waits for memory data.
// The output register holds one word; while the receiver stalls, the block
// accepts no further input once that register is occupied.
// Reset empties the ring and sets the trace mode to stopped; the record
// memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module trace_log_ring_buffer #(
    parameter int DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tlrb_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tlrb_pkg::out_word_t out_data
);
    import tlrb_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    trace_rec_t        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    trace_rec_t        mem_rd_data;

    tlrb_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tlrb_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
